// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
// Include once per file that asserts; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is high.
`define MCTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds through reset.
`define MCTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mcts_pkg.sv -----
// Shared types and constants of the motor channel timed sequencer.
// Used by the front, queue, back and top level; no dependencies.
`default_nettype none

package mcts_pkg;

   localparam int NumChannelsDefault = 4;
   localparam int MaxReport          = 4;
   localparam int QueueDepth         = 2;
   localparam int MaxDuty            = 100;

   localparam int DUTY_W = 7;
   localparam int TIME_W = 32;

   // Item kinds.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_PAUSE  = 2'd2;
   localparam logic [1:0] OP_RESUME = 2'd3;

   // Channel phases.
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ARMED = 2'd1;
   localparam logic [1:0] PH_DELAY = 2'd2;
   localparam logic [1:0] PH_HOLD  = 2'd3;

   // Notify codes: none, and a reserved code that is stored but never reported.
   localparam logic [1:0] MODE_NONE     = 2'd0;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // Classified command passed from the front to the back.
   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        chan;
      logic              start_ok;
      logic [DUTY_W-1:0] speed;
      logic              dir;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] hold;
      logic [1:0]        mode;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/mcts_front.sv -----
// Front end: unpacks request transfers, saturates the speed and checks the channel.
// Depends on mcts_pkg.
`default_nettype none

module mcts_front
   import mcts_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        q_ready,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic [7:0] raw_speed;
   logic [1:0] raw_chan;

   assign raw_chan   = req_tdata[1:0];
   assign raw_speed  = req_tdata[9:2];
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      q_cmd.op       = req_tuser;
      q_cmd.chan     = raw_chan;
      q_cmd.start_ok = (req_tuser == OP_START) && (32'(raw_chan) < NUM_CHANNELS);
      q_cmd.speed    = (32'(raw_speed) > MaxDuty) ? DUTY_W'(MaxDuty)
                                                  : raw_speed[DUTY_W-1:0];
      q_cmd.dir      = req_tdata[10];
      q_cmd.delay    = req_tdata[42:11];
      q_cmd.hold     = req_tdata[74:43];
      q_cmd.mode     = req_tdata[76:75];
   end

   `include "assert_macros.svh"

   `MCTS_ASSERT(a_front_push_ready, clock, reset, q_push |-> q_ready && req_tready, "push without room")

endmodule

`default_nettype wire

// ----- rtl/mcts_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on mcts_pkg.
`default_nettype none

module mcts_queue
   import mcts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         push_ready,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   localparam int PTR_W = $clog2(QueueDepth);
   localparam int CNT_W = $clog2(QueueDepth + 1);

   cmd_type            entry_ff [QueueDepth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `include "assert_macros.svh"

   `MCTS_ASSERT(a_queue_fill, clock, reset, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1, "queue count lost a push")
   `MCTS_ASSERT(a_queue_bound, clock, reset, count_ff <= CNT_W'(QueueDepth), "queue overfilled")

endmodule

`default_nettype wire

// ----- rtl/mcts_back.sv -----
// Back end: holds the channel state, carries out one command and serialises the report.
// Depends on mcts_pkg.
`default_nettype none

module mcts_back
   import mcts_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire cmd_type     q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   localparam int NREP = (NUM_CHANNELS < MaxReport) ? NUM_CHANNELS : MaxReport;

   // Channel state, one lane per channel.
   logic [1:0]        phase_ff  [NUM_CHANNELS], phase_in  [NUM_CHANNELS];
   logic [DUTY_W-1:0] duty_ff   [NUM_CHANNELS], duty_in   [NUM_CHANNELS];
   logic              pin_ff    [NUM_CHANNELS], pin_in    [NUM_CHANNELS];
   logic [DUTY_W-1:0] speed_ff  [NUM_CHANNELS], speed_in  [NUM_CHANNELS];
   logic              dset_ff   [NUM_CHANNELS], dset_in   [NUM_CHANNELS];
   logic [TIME_W-1:0] delay_ff  [NUM_CHANNELS], delay_in  [NUM_CHANNELS];
   logic [TIME_W-1:0] hold_ff   [NUM_CHANNELS], hold_in   [NUM_CHANNELS];
   logic [TIME_W-1:0] rem_ff    [NUM_CHANNELS], rem_in    [NUM_CHANNELS];
   logic [1:0]        mode_ff   [NUM_CHANNELS], mode_in   [NUM_CHANNELS];
   logic [DUTY_W-1:0] sduty_ff  [NUM_CHANNELS], sduty_in  [NUM_CHANNELS];
   logic [TIME_W-1:0] stime_ff  [NUM_CHANNELS], stime_in  [NUM_CHANNELS];
   logic [1:0]        sphase_ff [NUM_CHANNELS], sphase_in [NUM_CHANNELS];
   logic              done_c    [NUM_CHANNELS];
   logic [TIME_W-1:0] rem_dec   [NUM_CHANNELS];

   // Report snapshot, shown one channel per beat.
   logic [14:0] snap_ff [MaxReport];
   logic [14:0] snap_in [MaxReport];
   logic        snap_valid_ff, snap_valid_in;
   logic [1:0]  beat_ff, beat_in;
   logic        last_beat, rsp_xfer, pop;

   assign last_beat  = (beat_ff == 2'(NREP - 1));
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign pop        = q_valid && (!snap_valid_ff || (rsp_tready && last_beat));
   assign q_pop      = pop;
   assign rsp_tvalid = snap_valid_ff;
   assign rsp_tdata  = {1'b0, snap_ff[beat_ff]};
   assign rsp_tlast  = last_beat;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         phase_in[c]  = phase_ff[c];
         duty_in[c]   = duty_ff[c];
         pin_in[c]    = pin_ff[c];
         speed_in[c]  = speed_ff[c];
         dset_in[c]   = dset_ff[c];
         delay_in[c]  = delay_ff[c];
         hold_in[c]   = hold_ff[c];
         rem_in[c]    = rem_ff[c];
         mode_in[c]   = mode_ff[c];
         sduty_in[c]  = sduty_ff[c];
         stime_in[c]  = stime_ff[c];
         sphase_in[c] = sphase_ff[c];
         done_c[c]    = 1'b0;
         rem_dec[c]   = (rem_ff[c] != '0) ? rem_ff[c] - 1'b1 : rem_ff[c];

         case (q_cmd.op)
            OP_TICK: begin
               if (phase_ff[c] == PH_ARMED) begin
                  duty_in[c]  = '0;
                  rem_in[c]   = delay_ff[c];
                  phase_in[c] = PH_DELAY;
                  pin_in[c]   = dset_ff[c];
               end else if (phase_ff[c] inside {PH_DELAY, PH_HOLD}) begin
                  rem_in[c] = rem_dec[c];
                  if (rem_dec[c] == '0) begin
                     if (phase_ff[c] == PH_HOLD) begin
                        duty_in[c]  = '0;
                        phase_in[c] = PH_IDLE;
                        done_c[c]   = 1'b1;
                     end else begin
                        duty_in[c] = speed_ff[c];
                        if (hold_ff[c] == '0) begin
                           phase_in[c] = PH_IDLE;
                           done_c[c]   = 1'b1;
                        end else begin
                           rem_in[c]   = hold_ff[c];
                           phase_in[c] = PH_HOLD;
                        end
                     end
                  end
               end
            end
            OP_START: begin
               if (q_cmd.start_ok && (32'(q_cmd.chan) == c)) begin
                  phase_in[c] = PH_ARMED;
                  speed_in[c] = q_cmd.speed;
                  dset_in[c]  = q_cmd.dir;
                  delay_in[c] = q_cmd.delay;
                  hold_in[c]  = q_cmd.hold;
                  mode_in[c]  = q_cmd.mode;
               end
            end
            OP_PAUSE: begin
               if (phase_ff[c] != PH_IDLE) begin
                  sduty_in[c]  = duty_ff[c];
                  duty_in[c]   = '0;
                  stime_in[c]  = rem_ff[c];
                  sphase_in[c] = phase_ff[c];
                  phase_in[c]  = PH_IDLE;
               end
            end
            OP_RESUME: begin
               if (sphase_ff[c] != PH_IDLE) begin
                  duty_in[c]   = sduty_ff[c];
                  rem_in[c]    = stime_ff[c];
                  phase_in[c]  = sphase_ff[c];
                  sphase_in[c] = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result word per reported channel: done_mode, done_res, phase, dir_pin, duty, channel.
   always_comb begin
      for (int r = 0; r < MaxReport; r++) begin
         snap_in[r] = '0;
         if (r < NREP) begin
            snap_in[r] = {done_c[r] ? ((mode_in[r] == MODE_RESERVED) ? MODE_NONE
                                                                     : mode_in[r])
                                    : MODE_NONE,
                          done_c[r], phase_in[r], pin_in[r], duty_in[r], 2'(r)};
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      beat_in       = beat_ff;
      if (pop) begin
         snap_valid_in = 1'b1;
         beat_in       = '0;
      end else if (rsp_xfer) begin
         if (last_beat) begin
            snap_valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         beat_ff       <= '0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         beat_ff       <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            phase_ff[c]  <= PH_IDLE;
            duty_ff[c]   <= '0;
            pin_ff[c]    <= 1'b0;
            speed_ff[c]  <= '0;
            dset_ff[c]   <= 1'b0;
            delay_ff[c]  <= '0;
            hold_ff[c]   <= '0;
            rem_ff[c]    <= '0;
            mode_ff[c]   <= MODE_NONE;
            sduty_ff[c]  <= '0;
            stime_ff[c]  <= '0;
            sphase_ff[c] <= PH_IDLE;
         end
      end else if (pop) begin
         phase_ff  <= phase_in;
         duty_ff   <= duty_in;
         pin_ff    <= pin_in;
         speed_ff  <= speed_in;
         dset_ff   <= dset_in;
         delay_ff  <= delay_in;
         hold_ff   <= hold_in;
         rem_ff    <= rem_in;
         mode_ff   <= mode_in;
         sduty_ff  <= sduty_in;
         stime_ff  <= stime_in;
         sphase_ff <= sphase_in;
      end
   end

   `include "assert_macros.svh"

   `MCTS_ASSERT(a_back_load, clock, reset, pop |=> snap_valid_ff && beat_ff == '0, "report not loaded after command")
   `MCTS_ASSERT(a_back_stall, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(beat_ff), "report beat moved while stalled")
   `MCTS_ASSERT(a_back_hold_time, clock, reset, phase_ff[0] == PH_HOLD |-> rem_ff[0] != '0, "holding channel with no time left")

endmodule

`default_nettype wire

// ----- rtl/motor_channel_timed_sequencer_core.sv -----
// Motor channel timed sequencer: top level joining front end, command queue and back end.
// Depends on mcts_pkg, mcts_front, mcts_queue and mcts_back.
//
// Usage:
//   The req channel carries one command per transfer: a millisecond tick, a job
//   start for one channel, pause all or resume all (kind in req_tuser). Every
//   command produces one rsp transfer per reported channel (up to four, channel
//   0 first) giving duty, direction pin, phase and completion; rsp_tlast marks
//   the final one of a command.
//   A command is written into the queue and then popped into the report
//   snapshot register, from which its first result is shown. The report
//   serialiser shows one channel per cycle while rsp_tready is high; the back
//   end takes the next command from the queue in the cycle the last report
//   beat leaves, and meanwhile the queue keeps taking commands while it has room.
//   Stalls: while rsp_tready is low the current beat holds and the two-entry
//   queue keeps taking commands until it is full, then req_tready falls.
//   Reset: synchronous, active high; every channel returns to idle with zero
//   duty, pin and saved state, and the queue and report stage are emptied.
`default_nettype none

module motor_channel_timed_sequencer_core
   import mcts_pkg::*;
#(
   parameter int NUM_CHANNELS = NumChannelsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // channel[1:0], speed[9:2], direction[10], delay_ms[42:11], hold_ms[74:43],
   // notify_mode[76:75], zero fill above
   input  wire logic [79:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_channel[1:0], duty[8:2], dir_pin[9], phase[11:10], done_res[12],
   // done_mode[14:13], zero fill above
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic    q_ready, q_push, q_valid, q_pop;
   cmd_type push_cmd, pop_cmd;

   mcts_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   mcts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (pop_cmd)
   );

   mcts_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for motor_channel_timed_sequencer_core: directed and random commands,
// every channel report predicted in the bench and compared field by field. Needs mcts_pkg.
module tb_top;
   import mcts_pkg::*;

   localparam int NCH        = NumChannelsDefault;
   localparam int REPORTS    = (NCH < MaxReport) ? NCH : MaxReport;
   localparam int NUM_ITEMS  = 310;
   localparam int QUIET_MAX  = 2000;
   localparam int DRAIN_AT   = 160;
   localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(MaxDuty);

   typedef struct {
      logic [1:0]        func;
      logic [1:0]        chan;
      logic [7:0]        speed;
      logic              dir;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] hold;
      logic [1:0]        mode;
      bit                drain_first;
   } command_type;

   typedef struct {
      logic [1:0]        chan;
      logic [DUTY_W-1:0] duty;
      logic              pin;
      logic [1:0]        phase;
      logic              done;
      logic [1:0]        done_mode;
      logic              last;
   } report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   // Predicted channel state, starting from the reset state.
   logic [1:0]        run_phase [NCH] = '{default: PH_IDLE};
   logic [DUTY_W-1:0] run_duty  [NCH] = '{default: '0};
   logic              run_pin   [NCH] = '{default: 1'b0};
   logic [TIME_W-1:0] run_left  [NCH] = '{default: '0};
   logic [DUTY_W-1:0] job_speed [NCH] = '{default: '0};
   logic              job_dir   [NCH] = '{default: 1'b0};
   logic [TIME_W-1:0] job_delay [NCH] = '{default: '0};
   logic [TIME_W-1:0] job_hold  [NCH] = '{default: '0};
   logic [1:0]        job_mode  [NCH] = '{default: MODE_NONE};
   logic [DUTY_W-1:0] kept_duty [NCH] = '{default: '0};
   logic [TIME_W-1:0] kept_left [NCH] = '{default: '0};
   logic [1:0]        kept_phase[NCH] = '{default: PH_IDLE};

   command_type pending_cmds[$];
   report_type  expected_reports[$];
   command_type cur_cmd;
   report_type  seen, want;
   int       accepted_cmds = 0;
   int       mismatches    = 0;
   int       quiet_cycles  = 0;
   int       send_idle_pct = 38;
   int       recv_idle_pct = 56;

   motor_channel_timed_sequencer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // One millisecond tick for one channel; reports whether its job has finished.
   task automatic tick_channel(input int c, output bit finished);
      finished = 1'b0;
      case (run_phase[c])
         PH_ARMED: begin
            run_duty[c]  = '0;
            run_left[c]  = job_delay[c];
            run_phase[c] = PH_DELAY;
            run_pin[c]   = job_dir[c];
         end
         PH_DELAY, PH_HOLD: begin
            if (run_left[c] != 0) run_left[c]--;
            if (run_left[c] == 0) begin
               if (run_phase[c] == PH_HOLD) begin
                  run_duty[c]  = '0;
                  run_phase[c] = PH_IDLE;
                  finished     = 1'b1;
               end else begin
                  run_duty[c] = job_speed[c];
                  if (job_hold[c] == 0) begin
                     run_phase[c] = PH_IDLE;
                     finished     = 1'b1;
                  end else begin
                     run_left[c]  = job_hold[c];
                     run_phase[c] = PH_HOLD;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_command(input command_type cmd);
      bit         finished[NCH];
      report_type r;
      for (int c = 0; c < NCH; c++) finished[c] = 1'b0;
      case (cmd.func)
         OP_TICK: begin
            for (int c = 0; c < NCH; c++) tick_channel(c, finished[c]);
         end
         OP_START: begin
            if (cmd.chan < NCH) begin
               run_phase[cmd.chan] = PH_ARMED;
               job_speed[cmd.chan] = (cmd.speed > MaxDuty) ? FULL_DUTY : cmd.speed[DUTY_W-1:0];
               job_dir[cmd.chan]   = cmd.dir;
               job_delay[cmd.chan] = cmd.delay;
               job_hold[cmd.chan]  = cmd.hold;
               job_mode[cmd.chan]  = cmd.mode;
            end
         end
         OP_PAUSE: begin
            for (int c = 0; c < NCH; c++) begin
               if (run_phase[c] != PH_IDLE) begin
                  kept_duty[c]  = run_duty[c];
                  run_duty[c]   = '0;
                  kept_left[c]  = run_left[c];
                  kept_phase[c] = run_phase[c];
                  run_phase[c]  = PH_IDLE;
               end
            end
         end
         OP_RESUME: begin
            for (int c = 0; c < NCH; c++) begin
               if (kept_phase[c] != PH_IDLE) begin
                  run_duty[c]   = kept_duty[c];
                  run_left[c]   = kept_left[c];
                  run_phase[c]  = kept_phase[c];
                  kept_phase[c] = PH_IDLE;
               end
            end
         end
         default: ;
      endcase
      for (int c = 0; c < REPORTS; c++) begin
         r.chan      = c[1:0];
         r.duty      = run_duty[c];
         r.pin       = run_pin[c];
         r.phase     = run_phase[c];
         r.done      = finished[c];
         r.done_mode = (!finished[c] || job_mode[c] == MODE_RESERVED) ? MODE_NONE : job_mode[c];
         r.last      = (c == REPORTS - 1);
         expected_reports.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   function automatic command_type make_cmd(input logic [1:0] func, input logic [1:0] chan,
                                            input logic [7:0] speed, input logic dir,
                                            input logic [TIME_W-1:0] delay,
                                            input logic [TIME_W-1:0] hold,
                                            input logic [1:0] mode);
      command_type c;
      c.func        = func;
      c.chan        = chan;
      c.speed       = speed;
      c.dir         = dir;
      c.delay       = delay;
      c.hold        = hold;
      c.mode        = mode;
      c.drain_first = 1'b0;
      return c;
   endfunction

   // Short times let most jobs run to completion; wide ones reach every bit of the timers.
   function automatic command_type random_cmd(input logic [1:0] func, input bit wide);
      return make_cmd(func, 2'($urandom_range(3)), 8'($urandom_range(255)),
                      1'($urandom_range(1)),
                      wide ? $urandom() : $urandom_range(4),
                      wide ? $urandom() : $urandom_range(4),
                      2'($urandom_range(3)));
   endfunction

   // Driver: presents the oldest pending command and predicts it once transferred.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            predict_command(cur_cmd);
            accepted_cmds++;
         end
         if (pending_cmds.size() != 0
             && !(pending_cmds[0].drain_first && expected_reports.size() != 0)
             && $urandom_range(99) >= send_idle_pct) begin
            cur_cmd = pending_cmds.pop_front();
            req_tdata  <= {3'b0, cur_cmd.mode, cur_cmd.hold, cur_cmd.delay, cur_cmd.dir,
                           cur_cmd.speed, cur_cmd.chan};
            req_tuser  <= cur_cmd.func;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: every report transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.chan      = rsp_tdata[1:0];
            seen.duty      = rsp_tdata[8:2];
            seen.pin       = rsp_tdata[9];
            seen.phase     = rsp_tdata[11:10];
            seen.done      = rsp_tdata[12];
            seen.done_mode = rsp_tdata[14:13];
            seen.last      = rsp_tlast;
            if (expected_reports.size() == 0) begin
               $error("report transfer with none outstanding: channel %0d", seen.chan);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("out_channel", 32'(want.chan), 32'(seen.chan));
               check_field("duty", 32'(want.duty), 32'(seen.duty));
               check_field("dir_pin", 32'(want.pin), 32'(seen.pin));
               check_field("phase", 32'(want.phase), 32'(seen.phase));
               check_field("done_res", 32'(want.done), 32'(seen.done));
               check_field("done_mode", 32'(want.done_mode), 32'(seen.done_mode));
               check_field("last", 32'(want.last), 32'(seen.last));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int burst, ticks;
      // Directed opening: idle commands, extremes, replacement, pause and resume cases.
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_RESUME, 2'd3, 8'hFF, 1'b1, '1, '1, 2'd3));
      pending_cmds.push_back(make_cmd(OP_PAUSE, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_START, 2'd0, 8'd255, 1'b1, 0, 0, 2'd1));
      pending_cmds.push_back(make_cmd(OP_START, 2'd1, 8'd100, 1'b0, 1, 2, 2'd2));
      pending_cmds.push_back(make_cmd(OP_START, 2'd2, 8'd0, 1'b1, 0, 1, MODE_RESERVED));
      pending_cmds.push_back(make_cmd(OP_START, 2'd3, 8'd101, 1'b1, '1, '1, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd3, 8'hFF, 1'b1, '1, '1, 2'd3));
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      // Channel 2 is holding: the new job replaces it and leaves duty and pin alone.
      pending_cmds.push_back(make_cmd(OP_START, 2'd2, 8'd57, 1'b0, 2, 0, 2'd2));
      pending_cmds.push_back(make_cmd(OP_PAUSE, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      // A job started while paused is overridden by the resume.
      pending_cmds.push_back(make_cmd(OP_START, 2'd1, 8'd33, 1'b1, 1, 1, 2'd1));
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_RESUME, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_START, 2'd0, 8'd80, 1'b1, 3, 3, 2'd1));
      // Pause of an armed channel, re-armed by the resume and started on the tick after it.
      pending_cmds.push_back(make_cmd(OP_PAUSE, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      pending_cmds.push_back(make_cmd(OP_RESUME, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));
      for (int i = 0; i < 6; i++)
         pending_cmds.push_back(make_cmd(OP_TICK, 2'd0, 8'd0, 1'b0, 0, 0, MODE_NONE));

      // Random part: mostly jobs followed by one to eight ticks, plus noise.
      while (pending_cmds.size() < NUM_ITEMS) begin
         if ($urandom_range(99) < 75) begin
            burst = $urandom_range(1, 3);
            for (int i = 0; i < burst; i++)
               pending_cmds.push_back(random_cmd(OP_START, $urandom_range(9) == 0));
            ticks = $urandom_range(1, 8);
            for (int i = 0; i < ticks; i++)
               pending_cmds.push_back(random_cmd(OP_TICK, 1'($urandom_range(1))));
            if ($urandom_range(3) == 0) begin
               pending_cmds.push_back(random_cmd(OP_PAUSE, 1'($urandom_range(1))));
               ticks = $urandom_range(0, 2);
               for (int i = 0; i < ticks; i++)
                  pending_cmds.push_back(random_cmd(OP_TICK, 1'b0));
               if ($urandom_range(3) == 0)
                  pending_cmds.push_back(random_cmd(OP_START, 1'b0));
               pending_cmds.push_back(random_cmd(OP_RESUME, 1'($urandom_range(1))));
               ticks = $urandom_range(2, 6);
               for (int i = 0; i < ticks; i++)
                  pending_cmds.push_back(random_cmd(OP_TICK, 1'b0));
            end
         end else begin
            pending_cmds.push_back(random_cmd(2'($urandom_range(3)), 1'($urandom_range(1))));
         end
      end
      pending_cmds[DRAIN_AT].drain_first = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cmds < pending_cmds.size() / 3 + accepted_cmds / 2
             && accepted_cmds < NUM_ITEMS / 3)
         @(posedge clock);
      send_idle_pct = 56;
      recv_idle_pct = 38;
      while (accepted_cmds < 2 * NUM_ITEMS / 3) @(posedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;

      while (pending_cmds.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mcts_pkg.sv
rtl/mcts_front.sv
rtl/mcts_queue.sv
rtl/mcts_back.sv
rtl/motor_channel_timed_sequencer_core.sv
test/tb_top.sv
